FILE: sv/sps_pkg.sv
`default_nettype none

package sps_pkg;

   // pattern geometry
   localparam int STEPS     = 64;
   localparam int TRACKS    = 10;
   localparam int MEM_DEPTH = STEPS * TRACKS;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam int ROW_W     = $clog2(STEPS);

   // fixed field widths of the request and result channels
   localparam int STEP_W    = 6;
   localparam int TRK_W     = 4;
   localparam int KIND_W    = 2;
   localparam int NOTE_W    = 7;
   localparam int COUNT_W   = 32;
   localparam int VOICE_W   = 32;
   localparam int ENTRY_W   = KIND_W + 2 * NOTE_W;

   // request operations
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // pattern entry kinds
   localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ON    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_OFF   = 2'd2;

   // gate event codes
   localparam logic GATE_ON  = 1'b0;
   localparam logic GATE_OFF = 1'b1;

   // controller to datapath commands
   typedef struct packed {
      logic clear_en;
      logic write_en;
      logic tick_load;
      logic issue;
      logic final_flush;
   } sps_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic clear_done;
      logic tick_newer;
      logic issue_last;
   } sps_stat_type;

endpackage

`default_nettype wire

FILE: sv/sps_ctrl.sv
`default_nettype none

module sps_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic                 req_operation,
   input  wire sps_pkg::sps_stat_type stat,
   output logic                      busy,
   output sps_pkg::sps_cmd_type      cmd
);
   import sps_pkg::*;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_WALK  = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_FINAL = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       accept;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // sequence clearing, track walk, drain and flush
   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (stat.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept && req_operation == OP_WRITE) begin
               cmd.write_en = 1'b1;
            end else if (accept && stat.tick_newer) begin
               cmd.tick_load = 1'b1;
               state_in      = ST_WALK;
            end
         end
         ST_WALK: begin
            cmd.issue = 1'b1;
            if (stat.issue_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_FINAL;
         end
         ST_FINAL: begin
            cmd.final_flush = 1'b1;
            state_in        = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/sps_datapath.sv
`default_nettype none

module sps_datapath (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire sps_pkg::sps_cmd_type         cmd,
   output sps_pkg::sps_stat_type             stat,
   input  wire logic [sps_pkg::COUNT_W-1:0]  req_step_count,
   input  wire logic [sps_pkg::STEP_W-1:0]   req_write_step,
   input  wire logic [sps_pkg::TRK_W-1:0]    req_write_track,
   input  wire logic [sps_pkg::KIND_W-1:0]   req_write_kind,
   input  wire logic [sps_pkg::NOTE_W-1:0]   req_write_pitch,
   input  wire logic [sps_pkg::NOTE_W-1:0]   req_write_velocity,
   output logic                              rsp_strobe,
   output logic [sps_pkg::TRK_W-1:0]         rsp_track,
   output logic                              rsp_gate_event,
   output logic [sps_pkg::VOICE_W-1:0]       rsp_voice_id,
   output logic [sps_pkg::NOTE_W-1:0]        rsp_pitch,
   output logic [sps_pkg::NOTE_W-1:0]        rsp_velocity,
   output logic [sps_pkg::STEP_W-1:0]        rsp_row,
   output logic                              rsp_last
);
   import sps_pkg::*;

   // pattern memory and its ports
   logic [ENTRY_W-1:0] mem [MEM_DEPTH];
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [ENTRY_W-1:0] mem_wdata;
   logic [ADDR_W-1:0]  wr_addr;
   logic               wr_in_range;
   logic [ENTRY_W-1:0] wr_entry;

   logic [ADDR_W-1:0]  clr_addr_ff;

   // tick state
   logic [COUNT_W-1:0] last_step_ff;
   logic [VOICE_W-1:0] next_voice_ff;
   logic [VOICE_W-1:0] track_voice_ff [TRACKS];
   logic [ROW_W-1:0]   row_ff;
   logic [ROW_W-1:0]   tick_row;

   // walk pipeline
   logic [ADDR_W-1:0]  rd_addr_ff;
   logic [TRK_W-1:0]   rd_trk_ff;
   logic [ENTRY_W-1:0] rdata_ff;
   logic [TRK_W-1:0]   eval_trk_ff;
   logic               eval_vld_ff;

   // evaluated event
   logic               ev_hit;
   logic               ev_on;
   logic [VOICE_W-1:0] ev_id;
   logic [KIND_W-1:0]  ev_kind;
   logic [VOICE_W-1:0] cur_voice;

   // pending event waiting to learn whether it is the last one
   logic               pend_vld_ff;
   logic [TRK_W-1:0]   pend_trk_ff;
   logic               pend_gate_ff;
   logic [VOICE_W-1:0] pend_id_ff;
   logic [NOTE_W-1:0]  pend_pitch_ff;
   logic [NOTE_W-1:0]  pend_vel_ff;

   // output register
   logic               out_strobe_ff;
   logic [TRK_W-1:0]   out_trk_ff;
   logic               out_gate_ff;
   logic [VOICE_W-1:0] out_id_ff;
   logic [NOTE_W-1:0]  out_pitch_ff;
   logic [NOTE_W-1:0]  out_vel_ff;
   logic               out_last_ff;

   logic               emit_mid;
   logic               emit_final;

   // status toward the controller
   assign stat.clear_done = (clr_addr_ff == ADDR_W'(MEM_DEPTH - 1));
   assign stat.tick_newer = (req_step_count > last_step_ff);
   assign stat.issue_last = (rd_trk_ff == TRK_W'(TRACKS - 1));

   // build the write address and the stored entry
   assign wr_addr     = ADDR_W'(req_write_step) * ADDR_W'(TRACKS) + ADDR_W'(req_write_track);
   assign wr_in_range = (32'(req_write_step) < STEPS) && (32'(req_write_track) < TRACKS);
   always_comb begin
      if (req_write_kind == KIND_ON) begin
         wr_entry = {KIND_ON, req_write_pitch, req_write_velocity};
      end else if (req_write_kind == KIND_OFF) begin
         wr_entry = {KIND_OFF, {(2 * NOTE_W){1'b0}}};
      end else begin
         wr_entry = '0;
      end
   end

   // share the single write port between clearing and pattern writes
   assign mem_we    = cmd.clear_en || (cmd.write_en && wr_in_range);
   assign mem_waddr = cmd.clear_en ? clr_addr_ff : wr_addr;
   assign mem_wdata = cmd.clear_en ? '0 : wr_entry;

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
   end

   // read one entry per walk cycle
   always_ff @(posedge clock) begin
      if (cmd.issue) rdata_ff <= mem[rd_addr_ff];
   end

   // advance the clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear_en && !stat.clear_done) begin
         clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
      end
   end

   // row of this tick: count modulo the row count
   assign tick_row = ROW_W'(req_step_count % STEPS);

   // load the walk on a new tick, advance it per issue
   always_ff @(posedge clock) begin
      if (cmd.tick_load) begin
         row_ff     <= tick_row;
         rd_addr_ff <= ADDR_W'(tick_row) * ADDR_W'(TRACKS);
         rd_trk_ff  <= '0;
      end else if (cmd.issue) begin
         rd_addr_ff <= rd_addr_ff + ADDR_W'(1);
         rd_trk_ff  <= rd_trk_ff + TRK_W'(1);
      end
      if (cmd.issue) eval_trk_ff <= rd_trk_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eval_vld_ff <= 1'b0;
      end else begin
         eval_vld_ff <= cmd.issue;
      end
   end

   // decode the entry just read
   always_comb begin
      ev_kind   = rdata_ff[ENTRY_W-1 -: KIND_W];
      cur_voice = track_voice_ff[eval_trk_ff];
      ev_on     = (ev_kind == KIND_ON);
      ev_hit    = 1'b0;
      ev_id     = cur_voice;
      if (eval_vld_ff) begin
         if (ev_on) begin
            ev_hit = 1'b1;
            ev_id  = next_voice_ff;
         end else if (ev_kind == KIND_OFF) begin
            ev_hit = (cur_voice != '0);
         end
      end
   end

   // update voice bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         last_step_ff  <= '0;
         next_voice_ff <= VOICE_W'(1);
         for (int i = 0; i < TRACKS; i++) track_voice_ff[i] <= '0;
      end else begin
         if (cmd.tick_load) last_step_ff <= req_step_count;
         if (ev_hit && ev_on) begin
            next_voice_ff               <= next_voice_ff + VOICE_W'(1);
            track_voice_ff[eval_trk_ff] <= next_voice_ff;
         end else if (ev_hit) begin
            track_voice_ff[eval_trk_ff] <= '0;
         end
      end
   end

   // emit the pending event when a newer one arrives or the walk ends
   assign emit_mid   = ev_hit && pend_vld_ff;
   assign emit_final = cmd.final_flush && pend_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_vld_ff <= 1'b0;
      end else if (ev_hit) begin
         pend_vld_ff <= 1'b1;
      end else if (cmd.final_flush) begin
         pend_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ev_hit) begin
         pend_trk_ff   <= eval_trk_ff;
         pend_gate_ff  <= ev_on ? GATE_ON : GATE_OFF;
         pend_id_ff    <= ev_id;
         pend_pitch_ff <= ev_on ? rdata_ff[2*NOTE_W-1 -: NOTE_W] : '0;
         pend_vel_ff   <= ev_on ? rdata_ff[NOTE_W-1:0] : '0;
      end
   end

   // drive the result register for one cycle per event
   always_ff @(posedge clock) begin
      if (reset) begin
         out_strobe_ff <= 1'b0;
      end else begin
         out_strobe_ff <= emit_mid || emit_final;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_mid || emit_final) begin
         out_trk_ff   <= pend_trk_ff;
         out_gate_ff  <= pend_gate_ff;
         out_id_ff    <= pend_id_ff;
         out_pitch_ff <= pend_pitch_ff;
         out_vel_ff   <= pend_vel_ff;
         out_last_ff  <= emit_final;
      end
   end

   assign rsp_strobe     = out_strobe_ff;
   assign rsp_track      = out_trk_ff;
   assign rsp_gate_event = out_gate_ff;
   assign rsp_voice_id   = out_id_ff;
   assign rsp_pitch      = out_pitch_ff;
   assign rsp_velocity   = out_vel_ff;
   assign rsp_row        = STEP_W'(row_ff);
   assign rsp_last       = out_last_ff;

endmodule

`default_nettype wire

FILE: sv/pattern_step_sequencer.sv
`default_nettype none
// Looping step sequencer over a pattern of 64 rows by 10 tracks.
// Request channel: start with req_* fields is taken when busy is low.
//   A write request (req_operation = 1) stores one pattern entry in the
//   same cycle; busy stays low and no result follows. Out-of-range
//   positions are dropped.
//   A tick request (req_operation = 0) whose req_step_count exceeds the
//   last played count plays row count mod 64; other ticks are dropped.
// Result channel: rsp_strobe marks one event per cycle for exactly one
//   cycle; rsp_last flags the final event of a tick. The receiver cannot
//   stall the block, so results never wait.
// Tick walk: a played tick holds busy while the walk reads one pattern
//   entry per track through the single read port of the pattern memory,
//   then passes the drain and flush states; its last event is registered
//   in the flush state. Up to 10 events per tick, one per track.
// Reset: the pattern memory is swept empty one entry per cycle, so busy
//   stays high after reset until the sweep ends; voice ids restart at one.
module pattern_step_sequencer (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic                         req_operation,
   input  wire logic [sps_pkg::COUNT_W-1:0]  req_step_count,
   input  wire logic [sps_pkg::STEP_W-1:0]   req_write_step,
   input  wire logic [sps_pkg::TRK_W-1:0]    req_write_track,
   input  wire logic [sps_pkg::KIND_W-1:0]   req_write_kind,
   input  wire logic [sps_pkg::NOTE_W-1:0]   req_write_pitch,
   input  wire logic [sps_pkg::NOTE_W-1:0]   req_write_velocity,
   output logic                              rsp_strobe,
   output logic [sps_pkg::TRK_W-1:0]         rsp_track,
   output logic                              rsp_gate_event,
   output logic [sps_pkg::VOICE_W-1:0]       rsp_voice_id,
   output logic [sps_pkg::NOTE_W-1:0]        rsp_pitch,
   output logic [sps_pkg::NOTE_W-1:0]        rsp_velocity,
   output logic [sps_pkg::STEP_W-1:0]        rsp_row,
   output logic                              rsp_last
);
   import sps_pkg::*;

   sps_cmd_type  cmd;
   sps_stat_type stat;

   sps_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .stat          (stat),
      .busy          (busy),
      .cmd           (cmd)
   );

   sps_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_step_count     (req_step_count),
      .req_write_step     (req_write_step),
      .req_write_track    (req_write_track),
      .req_write_kind     (req_write_kind),
      .req_write_pitch    (req_write_pitch),
      .req_write_velocity (req_write_velocity),
      .rsp_strobe         (rsp_strobe),
      .rsp_track          (rsp_track),
      .rsp_gate_event     (rsp_gate_event),
      .rsp_voice_id       (rsp_voice_id),
      .rsp_pitch          (rsp_pitch),
      .rsp_velocity       (rsp_velocity),
      .rsp_row            (rsp_row),
      .rsp_last           (rsp_last)
   );

endmodule

`default_nettype wire

FILE: sv/sps_checker.sv
`default_nettype none

module sps_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         start,
   input wire logic                         busy,
   input wire logic                         req_operation,
   input wire logic                         rsp_strobe,
   input wire logic [sps_pkg::TRK_W-1:0]    rsp_track,
   input wire logic                         rsp_gate_event,
   input wire logic [sps_pkg::VOICE_W-1:0]  rsp_voice_id,
   input wire logic [sps_pkg::NOTE_W-1:0]   rsp_pitch,
   input wire logic [sps_pkg::NOTE_W-1:0]   rsp_velocity,
   input wire logic [sps_pkg::STEP_W-1:0]   rsp_row,
   input wire logic                         rsp_last
);
   import sps_pkg::*;

   // a write request completes at once
   a_write_no_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_operation == OP_WRITE |=> !busy)
      else $error("write request left the block busy");

   // the final event of a tick is followed by a quiet cycle
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |=> !rsp_strobe)
      else $error("event right after the last event of a tick");

   // a gate-off carries a live voice and no note data
   a_gate_off: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_gate_event == GATE_OFF |->
         rsp_voice_id != '0 && rsp_pitch == '0 && rsp_velocity == '0)
      else $error("malformed gate-off event");

   // events name an existing track
   a_track_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> 32'(rsp_track) < TRACKS)
      else $error("event track out of range");

   // hold the row across the events of one tick
   a_row_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |=> $stable(rsp_row))
      else $error("row changed within a tick");

endmodule

bind pattern_step_sequencer sps_checker u_sps_checker (.*);

`default_nettype wire
